/* rtl/mbps_pkg.sv */
`timescale 1ns / 1ps

package mbps_pkg;

    // Widths fixed by the register map and the item fields.
    localparam int PAT_BYTES  = 16;
    localparam int PAT_W      = 8 * PAT_BYTES;
    localparam int LEN_W      = 5;
    localparam int KIDX_W     = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CAND_W     = 32;
    localparam int OUT_OFF_W  = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_COUNT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_FIRST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CANDIDATE_SECOND = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCAN_ENABLE = 3'd7;

    // Result source codes.
    localparam logic [1:0] SRC_NONE   = 2'd0;
    localparam logic [1:0] SRC_FIRST  = 2'd1;
    localparam logic [1:0] SRC_SECOND = 2'd2;
    localparam logic [1:0] SRC_SCAN   = 2'd3;

    // Match settings shared by every window cell.
    typedef struct packed {
        logic [PAT_W-1:0]     pattern;
        logic [PAT_BYTES-1:0] care;
        logic [LEN_W-1:0]     len;
    } t_match_cfg;

    // Per-cycle shift control for the window cells.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

/* rtl/mbps_if.sv */
`timescale 1ns / 1ps

// Image byte channel.
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       last_byte;

    modport source (output valid, output image_byte, output last_byte, input ready);
    modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

// Scan result channel.
interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_offset;
    logic [1:0]  match_source;

    modport source (output valid, output found, output match_offset, output match_source,
                    input ready);
    modport sink   (input valid, input found, input match_offset, input match_source,
                    output ready);
endinterface

/* rtl/mbps_cell.sv */
`timescale 1ns / 1ps

// One window position. It compares the byte it is about to hold against the
// pattern byte that lines up with its age, then passes its stored byte on.
module mbps_cell #(
    parameter int AGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbps_pkg::t_cell_ctl i_ctl,
    input  mbps_pkg::t_match_cfg i_cfg,
    input  logic [7:0]          i_byte,
    output logic [7:0]          o_byte,
    output logic                o_ok
);

    logic [7:0]                    r_byte;
    logic [mbps_pkg::LEN_W-1:0]    age_w;
    logic [mbps_pkg::LEN_W-1:0]    k_full;
    logic [mbps_pkg::KIDX_W-1:0]   k_idx;
    logic [7:0]                    pat_byte;
    logic                          in_use;

    always_comb begin
        age_w    = mbps_pkg::LEN_W'(AGE);
        in_use   = age_w < i_cfg.len;
        k_full   = i_cfg.len - age_w - mbps_pkg::LEN_W'(1);
        k_idx    = k_full[mbps_pkg::KIDX_W-1:0];
        pat_byte = i_cfg.pattern[8*k_idx +: 8];
        o_ok     = !in_use || !i_cfg.care[k_idx] || (i_byte == pat_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_ctl.shift) begin
            r_byte <= i_ctl.clear ? 8'd0 : i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

/* rtl/masked_byte_pattern_scanner.sv */
`timescale 1ns / 1ps

// Masked byte pattern scanner.
// Image bytes arrive on i_in in offset order, one item per byte, with
// last_byte set on the final byte of an image. A row of window cells holds
// the most recent bytes; each accepted byte completes a window that is
// compared in the same cycle against the configured pattern, honoring the
// care mask. Matches at the two candidate offsets and the earliest match
// are remembered. When the last byte is accepted, one result item is loaded
// into the output register on o_out the next cycle: first candidate, then
// second candidate, then the earliest match if full scan is enabled, else
// not found. The stream state then clears and the next byte starts a new
// image at offset 0.
// Throughput is one byte per cycle while i_in.ready is high; the compare is
// done by all cells in parallel. i_in.ready is high whenever the output
// register is empty or being taken, so a stalled receiver holds the pending
// result and stops intake only while that register stays full. Reset
// (synchronous, active low) loads the register defaults and clears the
// window, counters and output valid.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data.
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    mbps_in_if.sink                           i_in,
    mbps_out_if.source                        o_out
);

    localparam int CMP_W = (OFFSET_BITS > mbps_pkg::CAND_W) ? OFFSET_BITS : mbps_pkg::CAND_W;

    // Configuration registers.
    logic [63:0]                   r_pattern_low;
    logic [63:0]                   r_pattern_high;
    logic [15:0]                   r_care_mask;
    logic [mbps_pkg::LEN_W-1:0]    r_pattern_length;
    logic [1:0]                    r_candidate_count;
    logic [mbps_pkg::CAND_W-1:0]   r_candidate_first;
    logic [mbps_pkg::CAND_W-1:0]   r_candidate_second;
    logic                          r_full_scan_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low      <= '0;
            r_pattern_high     <= '0;
            r_care_mask        <= 16'hFFFF;
            r_pattern_length   <= mbps_pkg::LEN_W'(1);
            r_candidate_count  <= '0;
            r_candidate_first  <= '0;
            r_candidate_second <= '0;
            r_full_scan_enable <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbps_pkg::REG_PATTERN_LOW: begin
                    r_pattern_low <= i_cfg_data;
                end
                mbps_pkg::REG_PATTERN_HIGH: begin
                    r_pattern_high <= i_cfg_data;
                end
                mbps_pkg::REG_CARE_MASK: begin
                    r_care_mask <= i_cfg_data[15:0];
                end
                mbps_pkg::REG_PATTERN_LENGTH: begin
                    r_pattern_length <= i_cfg_data[mbps_pkg::LEN_W-1:0];
                end
                mbps_pkg::REG_CANDIDATE_COUNT: begin
                    r_candidate_count <= i_cfg_data[1:0];
                end
                mbps_pkg::REG_CANDIDATE_FIRST: begin
                    r_candidate_first <= i_cfg_data[mbps_pkg::CAND_W-1:0];
                end
                mbps_pkg::REG_CANDIDATE_SECOND: begin
                    r_candidate_second <= i_cfg_data[mbps_pkg::CAND_W-1:0];
                end
                mbps_pkg::REG_FULL_SCAN_ENABLE: begin
                    r_full_scan_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Lengths above the window size act as the full window.
    logic [mbps_pkg::LEN_W-1:0] len_eff;
    assign len_eff = (r_pattern_length > mbps_pkg::LEN_W'(MAX_PATTERN))
                     ? mbps_pkg::LEN_W'(MAX_PATTERN) : r_pattern_length;

    // Handshake: the output register parts the two sides.
    logic in_fire;
    logic out_fire;
    logic r_out_valid;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = r_out_valid && o_out.ready;

    mbps_pkg::t_match_cfg match_cfg;
    mbps_pkg::t_cell_ctl  cell_ctl;

    assign match_cfg.pattern = {r_pattern_high, r_pattern_low};
    assign match_cfg.care    = r_care_mask;
    assign match_cfg.len     = len_eff;
    assign cell_ctl.shift    = in_fire;
    assign cell_ctl.clear    = i_in.last_byte;

    // Window cell chain: cell 0 takes the incoming byte, each later cell
    // takes its neighbor's stored byte.
    logic [7:0]             cell_in  [MAX_PATTERN];
    logic [7:0]             cell_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_ok;

    for (genvar a = 0; a < MAX_PATTERN; a++) begin : g_cell
        if (a == 0) begin : g_head
            assign cell_in[a] = i_in.image_byte;
        end else begin : g_link
            assign cell_in[a] = cell_out[a-1];
        end

        mbps_cell #(
            .AGE (a)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_cfg   (match_cfg),
            .i_byte  (cell_in[a]),
            .o_byte  (cell_out[a]),
            .o_ok    (cell_ok[a])
        );
    end

    // Stream state.
    logic [OFFSET_BITS-1:0] r_pos;
    logic [1:0]             r_cand_hits;
    logic                   r_scan_hit;
    logic [OFFSET_BITS-1:0] r_scan_off;

    logic                   pos_sat;
    logic                   window_hit;
    logic [mbps_pkg::LEN_W-1:0] len_m1;
    logic [OFFSET_BITS-1:0] start_off;
    logic [CMP_W-1:0]       start_ext;
    logic [1:0]             n_cand_hits;
    logic                   n_scan_hit;
    logic [OFFSET_BITS-1:0] n_scan_off;
    logic [OFFSET_BITS-1:0] n_pos;

    always_comb begin
        pos_sat    = (r_pos == {OFFSET_BITS{1'b1}});
        len_m1     = len_eff - mbps_pkg::LEN_W'(1);
        start_off  = r_pos - OFFSET_BITS'(len_m1);
        start_ext  = CMP_W'(start_off);
        // A window counts only once enough bytes have arrived for it.
        window_hit = !pos_sat && (len_eff != '0) && (r_pos >= OFFSET_BITS'(len_m1))
                     && (&cell_ok);

        n_cand_hits = r_cand_hits;
        n_scan_hit  = r_scan_hit;
        n_scan_off  = r_scan_off;
        if (window_hit) begin
            if (start_ext == CMP_W'(r_candidate_first)) begin
                n_cand_hits[0] = 1'b1;
            end
            if (start_ext == CMP_W'(r_candidate_second)) begin
                n_cand_hits[1] = 1'b1;
            end
            if (!r_scan_hit) begin
                n_scan_hit = 1'b1;
                n_scan_off = start_off;
            end
        end
        n_pos = pos_sat ? r_pos : r_pos + OFFSET_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_cand_hits <= '0;
            r_scan_hit  <= 1'b0;
            r_scan_off  <= '0;
        end else if (in_fire) begin
            if (i_in.last_byte) begin
                r_pos       <= '0;
                r_cand_hits <= '0;
                r_scan_hit  <= 1'b0;
                r_scan_off  <= '0;
            end else begin
                r_pos       <= n_pos;
                r_cand_hits <= n_cand_hits;
                r_scan_hit  <= n_scan_hit;
                r_scan_off  <= n_scan_off;
            end
        end
    end

    // Result selection, in priority order, for the byte marked last.
    logic        n_found;
    logic [31:0] n_offset;
    logic [1:0]  n_source;
    logic        use_first;
    logic        use_second;

    always_comb begin
        // A count of three acts as two: any nonzero count checks the first
        // candidate, and only a count of two or three checks the second.
        use_first  = (r_candidate_count != 2'd0);
        use_second = r_candidate_count[1];
        n_found    = 1'b0;
        n_offset   = '0;
        n_source   = mbps_pkg::SRC_NONE;
        priority if (use_first && n_cand_hits[0]) begin
            n_found  = 1'b1;
            n_offset = r_candidate_first;
            n_source = mbps_pkg::SRC_FIRST;
        end else if (use_second && n_cand_hits[1]) begin
            n_found  = 1'b1;
            n_offset = r_candidate_second;
            n_source = mbps_pkg::SRC_SECOND;
        end else if (r_full_scan_enable && n_scan_hit) begin
            n_found  = 1'b1;
            n_offset = mbps_pkg::OUT_OFF_W'(n_scan_off);
            n_source = mbps_pkg::SRC_SCAN;
        end else begin
            n_found  = 1'b0;
        end
    end

    // Output register.
    logic        r_found;
    logic [31:0] r_offset;
    logic [1:0]  r_source;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.last_byte) begin
            r_found  <= n_found;
            r_offset <= n_offset;
            r_source <= n_source;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.match_offset = r_offset;
    assign o_out.match_source = r_source;

endmodule

/* dv/tb_masked_byte_pattern_scanner.sv */
`timescale 1ns / 1ps

// Self-checking bench for the masked byte pattern scanner.
module tb_masked_byte_pattern_scanner;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DIRECTED_MAX = 25;
    localparam int MAX_WAIT     = 13;
    localparam int RUN_LIMIT    = 400000;
    localparam logic [7:0] CH_X = 8'h78;

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_byte_item;

    typedef struct packed {
        logic        found;
        logic [31:0] offset;
        logic [1:0]  source;
    } t_hit_report;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [mbps_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mbps_pkg::CFG_DATA_W-1:0] i_cfg_data;

    mbps_in_if  byte_ch ();
    mbps_out_if report_ch ();

    masked_byte_pattern_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (byte_ch),
        .o_out       (report_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow copy of the configuration registers, updated on every write.
    logic [8*mbps_pkg::PAT_BYTES-1:0] pat_bytes;
    logic [15:0]                      care_bits;
    logic [mbps_pkg::LEN_W-1:0]       len_reg;
    logic [1:0]                       cand_num;
    logic [31:0]                      cand_at [2];
    logic                             scan_all;

    // Shadow copy of the per-image stream state.
    logic [7:0]  win_bytes [mbps_pkg::PAT_BYTES];
    logic [31:0] byte_count;
    logic [1:0]  cand_seen;
    logic        first_hit_seen;
    logic [31:0] first_hit_at;

    t_byte_item  byte_backlog [$];
    t_hit_report predicted_reports [$];
    logic [7:0]  img_buf [$];

    int  items_queued = 0;
    int  items_taken  = 0;
    int  fail_count   = 0;
    int  cycle_count  = 0;
    int  send_wait    = 0;
    int  recv_wait    = 0;
    int  stall;
    bit  stim_live    = 1'b0;
    bit  send_calm    = 1'b1;
    bit  recv_calm    = 1'b1;
    bit  in_fire      = 1'b0;
    bit  out_fire     = 1'b0;
    t_byte_item next_byte;

    // Pattern length as the block uses it: values above the window depth
    // behave like a full-depth pattern.
    function automatic int used_len();
        return (len_reg > mbps_pkg::PAT_BYTES) ? mbps_pkg::PAT_BYTES : int'(len_reg);
    endfunction

    function automatic void clear_stream();
        foreach (win_bytes[i]) win_bytes[i] = 8'h00;
        byte_count     = '0;
        cand_seen      = '0;
        first_hit_seen = 1'b0;
        first_hit_at   = '0;
    endfunction

    // The window ending at the newest byte matches when every cared-for
    // pattern byte equals the image byte at the same position.
    function automatic bit window_hit(input int len);
        for (int k = 0; k < len; k++)
            if (care_bits[k] && win_bytes[len-1-k] != pat_bytes[8*k +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    // Advances the shadow stream by one accepted byte and, on the final
    // byte of an image, queues the report the block has to produce.
    function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
        int          len;
        logic [31:0] start;
        t_hit_report rep;
        len = used_len();
        for (int i = mbps_pkg::PAT_BYTES - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
        win_bytes[0] = b;
        // A saturated position counter stops all compares.
        if (byte_count != '1) begin
            if (len != 0 && 64'(byte_count) + 64'd1 >= 64'(len) && window_hit(len)) begin
                start = byte_count + 32'd1 - 32'(len);
                if (start == cand_at[0]) cand_seen[0] = 1'b1;
                if (start == cand_at[1]) cand_seen[1] = 1'b1;
                if (!first_hit_seen) begin
                    first_hit_seen = 1'b1;
                    first_hit_at   = start;
                end
            end
            byte_count = byte_count + 32'd1;
        end
        if (is_last) begin
            // A candidate count of three behaves like two.
            if (cand_num >= 2'd1 && cand_seen[0]) begin
                rep = '{1'b1, cand_at[0], mbps_pkg::SRC_FIRST};
            end else if (cand_num >= 2'd2 && cand_seen[1]) begin
                rep = '{1'b1, cand_at[1], mbps_pkg::SRC_SECOND};
            end else if (scan_all && first_hit_seen) begin
                rep = '{1'b1, first_hit_at, mbps_pkg::SRC_SCAN};
            end else begin
                rep = '{1'b0, 32'd0, mbps_pkg::SRC_NONE};
            end
            predicted_reports.push_back(rep);
            clear_stream();
        end
    endfunction

    function automatic void check_report(input t_hit_report got);
        t_hit_report want;
        if (predicted_reports.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: report with none pending: found=%0b offset=%0d source=%0d",
                         $time, got.found, got.offset, got.source);
            return;
        end
        want = predicted_reports.pop_front();
        if (got.found !== want.found || got.offset !== want.offset ||
            got.source !== want.source) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: report mismatch: expected found=%0b offset=%0d source=%0d, %s",
                         $time, want.found, want.offset, want.source,
                         $sformatf("got found=%0b offset=%0d source=%0d",
                                   got.found, got.offset, got.source));
        end
    endfunction

    // Draws the wait per item, up to MAX_WAIT; calm stretches run without gaps.
    function automatic int draw_wait(input bit calm);
        return calm ? 0 : int'($urandom_range(MAX_WAIT, 0));
    endfunction

    // Register writes happen on the falling edge so the block sees them
    // stable at the next rising edge. The shadow copy keeps only the bits
    // that the register holds.
    task automatic write_reg(input logic [mbps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mbps_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            mbps_pkg::REG_PATTERN_LOW:      pat_bytes[63:0]   = value;
            mbps_pkg::REG_PATTERN_HIGH:     pat_bytes[127:64] = value;
            mbps_pkg::REG_CARE_MASK:        care_bits         = value[15:0];
            mbps_pkg::REG_PATTERN_LENGTH:   len_reg           = value[mbps_pkg::LEN_W-1:0];
            mbps_pkg::REG_CANDIDATE_COUNT:  cand_num          = value[1:0];
            mbps_pkg::REG_CANDIDATE_FIRST:  cand_at[0]        = value[31:0];
            mbps_pkg::REG_CANDIDATE_SECOND: cand_at[1]        = value[31:0];
            mbps_pkg::REG_FULL_SCAN_ENABLE: scan_all          = value[0];
            default: ;
        endcase
    endtask

    // Half of the narrow register writes carry garbage above the register
    // width, which the block must drop.
    function automatic logic [mbps_pkg::CFG_DATA_W-1:0] with_junk(
        input logic [mbps_pkg::CFG_DATA_W-1:0] v,
        input int w);
        logic [mbps_pkg::CFG_DATA_W-1:0] keep;
        keep = (64'd1 << w) - 64'd1;
        if ($urandom_range(1, 0) == 0) return v & keep;
        return (v & keep) | ({$urandom, $urandom} & ~keep);
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(7, 0))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom;
            default: return $urandom_range(12, 0);
        endcase
    endfunction

    function automatic logic [63:0] pick_pattern();
        case ($urandom_range(3, 0))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Hands the image in img_buf to the driver, last byte flagged.
    task automatic send_image();
        for (int i = 0; i < img_buf.size(); i++) begin
            byte_backlog.push_back('{img_buf[i], i == img_buf.size() - 1});
            items_queued++;
        end
    endtask

    // Copies the active pattern into img_buf at the given offset when it fits.
    task automatic plant(input logic [31:0] pos);
        int len;
        len = used_len();
        if (len != 0 && 64'(pos) + 64'(len) <= 64'(img_buf.size()))
            for (int k = 0; k < len; k++) img_buf[pos + k] = pat_bytes[8*k +: 8];
    endtask

    // Most images mix pattern bytes with random bytes, with the pattern planted
    // at the candidate offsets or elsewhere, sometimes with one byte broken
    // afterward. The rest are plain noise.
    task automatic send_random_image();
        int n;
        int len;
        len = used_len();
        if ($urandom_range(4, 0) == 0) n = $urandom_range(64, 1);
        else n = len + $urandom_range(12, 0);
        if (n < 1) n = 1;
        img_buf.delete();
        if ($urandom_range(5, 0) == 0) begin
            repeat (n) img_buf.push_back(8'($urandom));
        end else begin
            repeat (n) begin
                if ($urandom_range(1, 0) == 0)
                    img_buf.push_back(
                        pat_bytes[8*$urandom_range(mbps_pkg::PAT_BYTES-1, 0) +: 8]);
                else
                    img_buf.push_back(8'($urandom));
            end
            if ($urandom_range(1, 0) == 0) plant(cand_at[0]);
            if ($urandom_range(1, 0) == 0) plant(cand_at[1]);
            if ($urandom_range(1, 0) == 0) plant($urandom_range(n - 1, 0));
            if ($urandom_range(3, 0) == 0)
                img_buf[$urandom_range(n - 1, 0)] ^= 8'(1 << $urandom_range(7, 0));
        end
        send_image();
    endtask

    // Holds the sender back until every byte is in and every report has
    // come out, then idles before returning.
    task automatic settle();
        while (items_taken != items_queued || predicted_reports.size() != 0)
            @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Sender: presents the next backlog byte once the previous one has been
    // taken and its drawn gap has run out.
    always @(negedge i_clk) begin
        if (stim_live && (!byte_ch.valid || in_fire)) begin
            if (send_wait > 0) begin
                byte_ch.valid <= 1'b0;
                send_wait     <= send_wait - 1;
            end else if (byte_backlog.size() != 0) begin
                next_byte          = byte_backlog.pop_front();
                byte_ch.valid      <= 1'b1;
                byte_ch.image_byte <= next_byte.data;
                byte_ch.last_byte  <= next_byte.is_last;
                send_wait          <= draw_wait(send_calm);
            end else begin
                byte_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: after taking a report it drops ready for a drawn number of
    // cycles, otherwise it stays ready.
    always @(negedge i_clk) begin
        if (stim_live) begin
            stall = out_fire ? draw_wait(recv_calm) : recv_wait;
            if (stall > 0) begin
                report_ch.ready <= 1'b0;
                recv_wait       <= stall - 1;
            end else begin
                report_ch.ready <= 1'b1;
                recv_wait       <= 0;
            end
        end
    end

    // Monitor: both handshakes are sampled at the rising edge. Accepted
    // bytes feed the predictor and accepted reports are checked in order.
    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && byte_ch.valid && byte_ch.ready;
        out_fire <= i_rst_n && report_ch.valid && report_ch.ready;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            absorb_byte(byte_ch.image_byte, byte_ch.last_byte);
            items_taken++;
        end
        if (i_rst_n && report_ch.valid && report_ch.ready)
            check_report('{report_ch.found, report_ch.match_offset, report_ch.match_source});
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= RUN_LIMIT) begin
            $display("masked_byte_pattern_scanner regression: fail");
            $finish;
        end
    end

    initial begin
        logic [mbps_pkg::CFG_DATA_W-1:0] lv;

        // Every input starts at a known value and the shadow registers start
        // at the reset defaults.
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = '0;
        i_cfg_data           = '0;
        byte_ch.valid        = 1'b0;
        byte_ch.image_byte   = 8'h00;
        byte_ch.last_byte    = 1'b0;
        report_ch.ready      = 1'b0;
        pat_bytes            = '0;
        care_bits            = 16'hFFFF;
        len_reg              = mbps_pkg::LEN_W'(1);
        cand_num             = 2'd0;
        cand_at[0]           = '0;
        cand_at[1]           = '0;
        scan_all             = 1'b1;
        clear_stream();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n   = 1'b1;
        stim_live = 1'b1;

        // Reset settings: a one-byte pattern of zero, so the earliest zero
        // byte is reported by the full scan.
        img_buf = '{8'hFF, 8'h00};
        send_image();
        img_buf = '{8'h00};
        send_image();
        settle();

        // A zero pattern length never matches.
        write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'd0);
        img_buf = '{8'h00};
        send_image();
        settle();

        // A length above the window depth acts as a full sixteen-byte pattern.
        write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'd31);
        write_reg(mbps_pkg::REG_PATTERN_LOW, {8{CH_X}});
        write_reg(mbps_pkg::REG_PATTERN_HIGH, {8{CH_X}});
        img_buf.delete();
        repeat (mbps_pkg::PAT_BYTES) img_buf.push_back(CH_X);
        send_image();
        settle();

        // Three-byte pattern with a wildcard in the middle and care bits set
        // past its end. A count of three still checks two candidates; the
        // second one wins because the first never matches.
        write_reg(mbps_pkg::REG_PATTERN_LENGTH, 64'd3);
        write_reg(mbps_pkg::REG_PATTERN_LOW, {{5{CH_X}}, CH_X, 8'h79, CH_X});
        write_reg(mbps_pkg::REG_CARE_MASK, 64'hFFFD);
        write_reg(mbps_pkg::REG_CANDIDATE_COUNT, 64'd3);
        write_reg(mbps_pkg::REG_CANDIDATE_FIRST, 64'd1);
        write_reg(mbps_pkg::REG_CANDIDATE_SECOND, 64'd0);
        write_reg(mbps_pkg::REG_FULL_SCAN_ENABLE, 64'd0);
        img_buf = '{CH_X, 8'h41, CH_X, 8'h42, CH_X};
        send_image();
        settle();

        // Random part: each phase writes every register, then streams a
        // handful of images, then drains completely before the next phase.
        while (items_queued < DIRECTED_MAX + RANDOM_ITEMS) begin
            send_calm = ($urandom_range(3, 0) == 0);
            recv_calm = ($urandom_range(3, 0) == 0);
            write_reg(mbps_pkg::REG_PATTERN_LOW, pick_pattern());
            write_reg(mbps_pkg::REG_PATTERN_HIGH, pick_pattern());
            case ($urandom_range(3, 0))
                0:       lv = 64'd0;
                1:       lv = 64'hFFFF;
                default: lv = 64'($urandom_range(16'hFFFF, 0));
            endcase
            write_reg(mbps_pkg::REG_CARE_MASK, with_junk(lv, 16));
            case ($urandom_range(9, 0))
                0:       lv = 64'd0;
                1:       lv = 64'd16;
                2:       lv = 64'($urandom_range(31, 17));
                3:       lv = 64'($urandom_range(15, 7));
                default: lv = 64'($urandom_range(6, 1));
            endcase
            write_reg(mbps_pkg::REG_PATTERN_LENGTH, with_junk(lv, mbps_pkg::LEN_W));
            write_reg(mbps_pkg::REG_CANDIDATE_COUNT,
                      with_junk(64'($urandom_range(3, 0)), 2));
            write_reg(mbps_pkg::REG_CANDIDATE_FIRST, with_junk(64'(pick_offset()), 32));
            write_reg(mbps_pkg::REG_CANDIDATE_SECOND, with_junk(64'(pick_offset()), 32));
            write_reg(mbps_pkg::REG_FULL_SCAN_ENABLE,
                      with_junk(64'($urandom_range(3, 0) != 0), 1));
            repeat ($urandom_range(12, 3)) send_random_image();
            settle();
        end

        repeat (8) @(posedge i_clk);
        if (predicted_reports.size() != 0) fail_count++;
        if (fail_count == 0) begin
            $display("masked_byte_pattern_scanner regression: pass");
        end else begin
            $display("masked_byte_pattern_scanner regression: fail");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/mbps_pkg.sv
rtl/mbps_if.sv
rtl/mbps_cell.sv
rtl/masked_byte_pattern_scanner.sv
dv/tb_masked_byte_pattern_scanner.sv
